// ===== sv/fupd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fupd_pkg: shared types, constants and helpers for the file URL path decoder
// Holds the prefix texts, the symbol and result beat layouts and hex helpers.
// ----------------------------------------------------------------------------
package fupd_pkg;

    // field widths
    localparam int BYTE_W  = 8;
    localparam int LIMIT_W = 9;
    localparam int CNT_W   = 4;

    // prefix lengths
    localparam int SCHEME_LEN = 7;
    localparam int HOST_LEN   = 10;

    // defaults handed to the top level
    localparam int PATH_BUFFER_BYTES_DEF = 512;
    localparam int QUEUE_DEPTH           = 4;

    // special characters
    localparam logic [BYTE_W-1:0] CH_PCT   = 8'h25;
    localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;

    // register reset value
    localparam logic [LIMIT_W-1:0] OUT_LIMIT_RST = 9'd511;

    // one decoder symbol, front to back
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              has_byte;
        logic              is_end;
    } t_sym;

    // one result beat
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              byte_valid;
        logic              end_of_path;
        logic              truncated;
    } t_res;

    localparam int SYM_W = $bits(t_sym);
    localparam int RES_W = $bits(t_res);

    // character of "file://" or "localhost/" at a position
    function automatic logic [BYTE_W-1:0] prefix_char(input logic host,
                                                      input logic [CNT_W-1:0] idx);
        logic [BYTE_W-1:0] ch;
        ch = 8'h00;
        if (host) begin
            unique case (idx)
                4'd0:    ch = 8'h6C; // l
                4'd1:    ch = 8'h6F; // o
                4'd2:    ch = 8'h63; // c
                4'd3:    ch = 8'h61; // a
                4'd4:    ch = 8'h6C; // l
                4'd5:    ch = 8'h68; // h
                4'd6:    ch = 8'h6F; // o
                4'd7:    ch = 8'h73; // s
                4'd8:    ch = 8'h74; // t
                4'd9:    ch = 8'h2F; // /
                default: ch = 8'h00;
            endcase
        end else begin
            unique case (idx)
                4'd0:    ch = 8'h66; // f
                4'd1:    ch = 8'h69; // i
                4'd2:    ch = 8'h6C; // l
                4'd3:    ch = 8'h65; // e
                4'd4:    ch = 8'h3A; // :
                4'd5:    ch = 8'h2F; // /
                4'd6:    ch = 8'h2F; // /
                default: ch = 8'h00;
            endcase
        end
        return ch;
    endfunction

    // hex digit of either case
    function automatic logic is_hex(input logic [BYTE_W-1:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) ||
               ((c >= 8'h41) && (c <= 8'h46)) ||
               ((c >= 8'h61) && (c <= 8'h66));
    endfunction

    // nibble value of a hex digit
    function automatic logic [3:0] hex_val(input logic [BYTE_W-1:0] c);
        logic [3:0] v;
        if (c <= 8'h39) begin
            v = c[3:0];
        end else begin
            v = c[3:0] + 4'd9;
        end
        return v;
    endfunction

endpackage

// ===== sv/fupd_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fupd_fifo: small register queue
// Push/full on one side, pop/empty on the other, head shown while not empty.
// ----------------------------------------------------------------------------
module fupd_fifo #(
    parameter int WIDTH = fupd_pkg::SYM_W,
    parameter int DEPTH = fupd_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, n_wr;
    logic [AW-1:0]    r_rd, n_rd;
    logic [AW:0]      r_cnt, n_cnt;
    logic             do_push, do_pop;

    // status
    assign o_full  = (r_cnt == AW'(0) + (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    // pointer and count update
    always_comb begin
        n_wr  = do_push ? r_wr + AW'(1) : r_wr;
        n_rd  = do_pop  ? r_rd + AW'(1) : r_rd;
        n_cnt = r_cnt;
        unique case ({do_push, do_pop})
            2'b10:   n_cnt = r_cnt + (AW+1)'(1);
            2'b01:   n_cnt = r_cnt - (AW+1)'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

// ===== sv/fupd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fupd_front: prefix stripper
// Matches "file://" then "localhost/", and turns each input beat into decoder
// symbols; a partial prefix is replayed one character a cycle unless stalled.
// ----------------------------------------------------------------------------
module fupd_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  logic [fupd_pkg::BYTE_W-1:0] i_in_byte,
    input  logic                        i_in_last,
    output logic                        o_full,
    output logic                        o_sym_push,
    output fupd_pkg::t_sym              o_sym,
    input  logic                        i_sym_full
);
    import fupd_pkg::*;

    typedef enum logic [2:0] {
        PS_SCHEME = 3'b001,
        PS_HOST   = 3'b010,
        PS_DECODE = 3'b100
    } t_pstage;

    typedef enum logic [1:0] {
        FM_PASS  = 2'b01,
        FM_FLUSH = 2'b10
    } t_fmode;

    t_pstage           r_pstage, n_pstage;
    t_fmode            r_mode, n_mode;
    logic [CNT_W-1:0]  r_match, n_match;
    logic [CNT_W-1:0]  r_fl_idx, n_fl_idx;
    logic [CNT_W-1:0]  r_fl_cnt;
    logic              r_fl_host;
    logic [BYTE_W-1:0] r_fl_byte;
    logic              r_fl_feed;
    logic              r_fl_end;

    logic              accept;
    logic              in_host;
    logic [BYTE_W-1:0] m_ch;
    logic [CNT_W-1:0]  m_len;
    logic [CNT_W-1:0]  m1;
    logic              hit;
    logic [CNT_W-1:0]  plan_n;
    logic              plan_host;
    logic              plan_feed;
    logic [BYTE_W-1:0] plan_byte;
    logic              plan_end;

    // input handshake
    assign o_full = (r_mode == FM_FLUSH) || i_sym_full;
    assign accept = i_push && !o_full;

    // prefix compare
    assign in_host = (r_pstage == PS_HOST);
    assign m_ch    = prefix_char(in_host, r_match);
    assign m_len   = in_host ? CNT_W'(HOST_LEN) : CNT_W'(SCHEME_LEN);
    assign m1      = r_match + CNT_W'(1);
    assign hit     = (r_match < m_len) && (i_in_byte == m_ch);

    // classify the accepted beat
    always_comb begin
        n_pstage  = r_pstage;
        n_match   = r_match;
        plan_n    = '0;
        plan_host = 1'b0;
        plan_feed = 1'b0;
        plan_byte = i_in_byte;
        plan_end  = i_in_last;
        if (accept) begin
            unique case (r_pstage)
                PS_SCHEME: begin
                    if (hit) begin
                        if (m1 == CNT_W'(SCHEME_LEN)) begin
                            n_pstage = PS_HOST;
                            n_match  = '0;
                        end else begin
                            n_match = m1;
                            if (i_in_last) begin
                                plan_n = m1;
                            end
                        end
                    end else begin
                        plan_n    = r_match;
                        plan_feed = 1'b1;
                        n_pstage  = PS_DECODE;
                        n_match   = '0;
                    end
                end
                PS_HOST: begin
                    plan_host = 1'b1;
                    if (hit) begin
                        if (m1 == CNT_W'(HOST_LEN)) begin
                            plan_feed = 1'b1;
                            plan_byte = CH_SLASH;
                            n_pstage  = PS_DECODE;
                            n_match   = '0;
                        end else begin
                            n_match = m1;
                            if (i_in_last) begin
                                plan_n = m1;
                            end
                        end
                    end else begin
                        plan_n    = r_match;
                        plan_feed = 1'b1;
                        n_pstage  = PS_DECODE;
                        n_match   = '0;
                    end
                end
                default: begin
                    plan_feed = 1'b1;
                end
            endcase
            // new path after the last beat
            if (i_in_last) begin
                n_pstage = PS_SCHEME;
                n_match  = '0;
            end
        end
    end

    // symbol out: direct beat or replay of held prefix characters
    always_comb begin
        n_mode     = r_mode;
        n_fl_idx   = r_fl_idx;
        o_sym_push = 1'b0;
        o_sym      = '{data: plan_byte, has_byte: plan_feed, is_end: plan_end};
        if (r_mode == FM_FLUSH) begin
            if (r_fl_idx == r_fl_cnt) begin
                o_sym = '{data: r_fl_byte, has_byte: r_fl_feed, is_end: r_fl_end};
            end else begin
                o_sym = '{data: prefix_char(r_fl_host, r_fl_idx), has_byte: 1'b1,
                          is_end: 1'b0};
            end
            if (!i_sym_full) begin
                o_sym_push = 1'b1;
                if (r_fl_idx == r_fl_cnt) begin
                    n_mode = FM_PASS;
                end else begin
                    n_fl_idx = r_fl_idx + CNT_W'(1);
                end
            end
        end else if (accept) begin
            if (plan_n != '0) begin
                n_mode   = FM_FLUSH;
                n_fl_idx = '0;
            end else begin
                o_sym_push = plan_feed || plan_end;
            end
        end
    end

    // replay plan, loaded when a flush starts
    always_ff @(posedge i_clk) begin
        if (accept && (r_mode == FM_PASS) && (plan_n != '0)) begin
            r_fl_cnt  <= plan_n;
            r_fl_host <= plan_host;
            r_fl_byte <= plan_byte;
            r_fl_feed <= plan_feed;
            r_fl_end  <= plan_end;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pstage <= PS_SCHEME;
            r_mode   <= FM_PASS;
            r_match  <= '0;
            r_fl_idx <= '0;
        end else begin
            r_pstage <= n_pstage;
            r_mode   <= n_mode;
            r_match  <= n_match;
            r_fl_idx <= n_fl_idx;
        end
    end

endmodule

// ===== sv/fupd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fupd_back: percent decoder and byte limiter
// Takes one symbol from the queue, emits at most one result beat a cycle,
// applies the byte limit and closes each path with an end marker.
// ----------------------------------------------------------------------------
module fupd_back #(
    parameter int PATH_BUFFER_BYTES = fupd_pkg::PATH_BUFFER_BYTES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [fupd_pkg::LIMIT_W-1:0] i_out_limit,
    input  fupd_pkg::t_sym               i_sym,
    input  logic                         i_sym_empty,
    output logic                         o_sym_pop,
    output logic                         o_res_push,
    output fupd_pkg::t_res               o_res,
    input  logic                         i_res_full
);
    import fupd_pkg::*;

    localparam int CAP_RAW = PATH_BUFFER_BYTES - 1;
    localparam int CAP_MAX = (1 << LIMIT_W) - 1;
    localparam int CAP_INT = (CAP_RAW < CAP_MAX) ? CAP_RAW : CAP_MAX;
    localparam logic [LIMIT_W-1:0] LIMIT_CAP = CAP_INT[LIMIT_W-1:0];

    // pending escape: none, '%' seen, '%' and a digit seen, held digit to emit
    typedef enum logic [3:0] {
        ES_NONE = 4'b0001,
        ES_PCT  = 4'b0010,
        ES_DIG  = 4'b0100,
        ES_HELD = 4'b1000
    } t_esc;

    t_esc               r_esc, n_esc;
    logic [BYTE_W-1:0]  r_held, n_held;
    logic               r_byte_done, n_byte_done;
    logic [LIMIT_W-1:0] r_written;
    logic               r_dropped;

    logic               step;
    logic               emit;
    logic [BYTE_W-1:0]  emit_byte;
    logic               mark;
    logic               c_hex;
    logic [LIMIT_W-1:0] limit;
    logic               room;

    assign step  = !i_sym_empty && !i_res_full;
    assign c_hex = is_hex(i_sym.data);
    assign limit = (i_out_limit < LIMIT_CAP) ? i_out_limit : LIMIT_CAP;
    assign room  = (r_written < limit);

    // decode one step of the head symbol
    always_comb begin
        n_esc       = r_esc;
        n_held      = r_held;
        n_byte_done = r_byte_done;
        emit        = 1'b0;
        emit_byte   = i_sym.data;
        mark        = 1'b0;
        o_sym_pop   = 1'b0;
        if (step) begin
            if (i_sym.has_byte && !r_byte_done) begin
                unique case (r_esc)
                    ES_PCT: begin
                        if (c_hex) begin
                            n_held      = i_sym.data;
                            n_esc       = ES_DIG;
                            n_byte_done = 1'b1;
                        end else begin
                            emit      = 1'b1;
                            emit_byte = CH_PCT;
                            n_esc     = ES_NONE;
                        end
                    end
                    ES_DIG: begin
                        if (c_hex) begin
                            emit        = 1'b1;
                            emit_byte   = {hex_val(r_held), hex_val(i_sym.data)};
                            n_esc       = ES_NONE;
                            n_byte_done = 1'b1;
                        end else begin
                            emit      = 1'b1;
                            emit_byte = CH_PCT;
                            n_esc     = ES_HELD;
                        end
                    end
                    ES_HELD: begin
                        emit      = 1'b1;
                        emit_byte = r_held;
                        n_esc     = ES_NONE;
                    end
                    default: begin
                        n_esc       = (i_sym.data == CH_PCT) ? ES_PCT : ES_NONE;
                        emit        = (i_sym.data != CH_PCT);
                        n_byte_done = 1'b1;
                    end
                endcase
            end else if (i_sym.is_end) begin
                // end of input counts as a non-hex byte
                unique case (r_esc)
                    ES_PCT: begin
                        emit      = 1'b1;
                        emit_byte = CH_PCT;
                        n_esc     = ES_NONE;
                    end
                    ES_DIG: begin
                        emit      = 1'b1;
                        emit_byte = CH_PCT;
                        n_esc     = ES_HELD;
                    end
                    ES_HELD: begin
                        emit      = 1'b1;
                        emit_byte = r_held;
                        n_esc     = ES_NONE;
                    end
                    default: begin
                        mark  = 1'b1;
                        n_esc = ES_NONE;
                    end
                endcase
            end else begin
                o_sym_pop   = 1'b1;
                n_byte_done = 1'b0;
            end
            // retire the symbol once its work is done
            if ((n_byte_done && !i_sym.is_end) || mark) begin
                o_sym_pop   = 1'b1;
                n_byte_done = 1'b0;
            end
        end
    end

    // result beat
    always_comb begin
        o_res_push = mark || (emit && room);
        if (mark) begin
            o_res = '{data: '0, byte_valid: 1'b0, end_of_path: 1'b1,
                      truncated: r_dropped};
        end else begin
            o_res = '{data: emit_byte, byte_valid: 1'b1, end_of_path: 1'b0,
                      truncated: 1'b0};
        end
    end

    // held digit
    always_ff @(posedge i_clk) begin
        r_held <= n_held;
    end

    // control state and limit bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc       <= ES_NONE;
            r_byte_done <= 1'b0;
            r_written   <= '0;
            r_dropped   <= 1'b0;
        end else begin
            r_esc       <= n_esc;
            r_byte_done <= n_byte_done;
            if (mark) begin
                r_written <= '0;
                r_dropped <= 1'b0;
            end else if (emit) begin
                if (room) begin
                    r_written <= r_written + LIMIT_W'(1);
                end else begin
                    r_dropped <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== sv/file_url_path_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// file_url_path_decoder: file URL to local path converter
// Strips "file://" and "localhost", percent-decodes, limits and marks paths.
// ----------------------------------------------------------------------------
// Push one URL byte per beat with i_in_last on the final one; pop decoded
// path bytes, each path closed by a marker beat (o_byte_valid low,
// o_end_of_path high, o_truncated set if the byte limit dropped anything).
// Plain bytes run at one per cycle while no queue is full. A prefix that
// matches only in part is replayed by the stripper one held character a
// cycle while the symbol queue has room, then the mismatching byte; full
// stays high. The decoder takes a step per result beat, so an escape that
// falls back to literal text takes a step per literal character, and the
// end marker one more. Four-entry queues sit between stripper and decoder
// and in front of the result ports. The user must write the limit in
// i_cfg_data only while the block is idle; the block does not enforce it.
// The effective limit is the smaller of it and PATH_BUFFER_BYTES - 1.
// ----------------------------------------------------------------------------
module file_url_path_decoder #(
    parameter int PATH_BUFFER_BYTES = fupd_pkg::PATH_BUFFER_BYTES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input beats
    input  logic                         push,
    output logic                         full,
    input  logic [fupd_pkg::BYTE_W-1:0]  i_in_byte,
    input  logic                         i_in_last,
    // result beats
    output logic                         empty,
    input  logic                         pop,
    output logic [fupd_pkg::BYTE_W-1:0]  o_out_byte,
    output logic                         o_byte_valid,
    output logic                         o_end_of_path,
    output logic                         o_truncated,
    // configuration
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [fupd_pkg::LIMIT_W-1:0] i_cfg_data
);
    import fupd_pkg::*;

    logic [LIMIT_W-1:0] r_out_limit;
    logic               sym_push, sym_full, sym_empty, sym_pop;
    t_sym               sym_in, sym_out;
    logic               res_push, res_full;
    t_res               res_in, res_out;

    // limit register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_limit <= OUT_LIMIT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_out_limit <= i_cfg_data;
        end
    end

    // prefix stripper
    fupd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_in_byte  (i_in_byte),
        .i_in_last  (i_in_last),
        .o_full     (full),
        .o_sym_push (sym_push),
        .o_sym      (sym_in),
        .i_sym_full (sym_full)
    );

    // symbol queue
    fupd_fifo #(
        .WIDTH (SYM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_sym_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (sym_push),
        .i_data  (sym_in),
        .o_full  (sym_full),
        .i_pop   (sym_pop),
        .o_data  (sym_out),
        .o_empty (sym_empty)
    );

    // percent decoder
    fupd_back #(
        .PATH_BUFFER_BYTES (PATH_BUFFER_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_out_limit (r_out_limit),
        .i_sym       (sym_out),
        .i_sym_empty (sym_empty),
        .o_sym_pop   (sym_pop),
        .o_res_push  (res_push),
        .o_res       (res_in),
        .i_res_full  (res_full)
    );

    // result queue
    fupd_fifo #(
        .WIDTH (RES_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_out),
        .o_empty (empty)
    );

    // result ports
    assign o_out_byte    = res_out.data;
    assign o_byte_valid  = res_out.byte_valid;
    assign o_end_of_path = res_out.end_of_path;
    assign o_truncated   = res_out.truncated;

    // a result is either a path byte or the end marker, never both or neither
    a_byte_or_marker : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_byte_valid != o_end_of_path))
        else $error("result beat is neither a byte nor a marker");

    // truncation is reported only on the marker
    a_trunc_on_marker : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_byte_valid) |-> !o_truncated)
        else $error("truncated set on a path byte");

    // reset leaves no results behind
    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

endmodule
